@@ hdl/cube_face_projection_jacobian_unit_assert.svh @@
// assertion macros for the cube face jacobian unit
// each macro expects clk and rst_n in scope
`ifndef CUBE_FACE_PROJECTION_JACOBIAN_UNIT_ASSERT_SVH
`define CUBE_FACE_PROJECTION_JACOBIAN_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
`define CFPJ_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define CFPJ_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define CFPJ_ASSERT_IMP(lbl, ante, cons)
`define CFPJ_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

@@ hdl/cfpj_pkg.sv @@
package cfpj_pkg;

    localparam int DIV_STEPS  = 4;
    localparam int DIV_STAGES = 8;
    localparam int LANES      = 6;

    typedef enum logic [1:0] {
        ERR_NONE  = 2'd0,
        ERR_FACE  = 2'd1,
        ERR_DEPTH = 2'd2
    } err_code_t;

    typedef enum logic [2:0] {
        FACE_FRONT = 3'd0,
        FACE_LEFT  = 3'd1,
        FACE_RIGHT = 3'd2,
        FACE_LOWER = 3'd3,
        FACE_UPPER = 3'd4
    } face_t;

    typedef enum logic {
        CFG_FOCAL_X = 1'b0,
        CFG_FOCAL_Y = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
        logic [2:0]         face;
    } in_item_t;

    typedef struct packed {
        logic               row_index;
        logic signed [31:0] j_rot_x;
        logic signed [31:0] j_rot_y;
        logic signed [31:0] j_rot_z;
        logic signed [31:0] j_trans_x;
        logic signed [31:0] j_trans_y;
        logic signed [31:0] j_trans_z;
        logic               saturated;
        logic [1:0]         error_code;
        logic               last;
    } result_t;

    typedef struct packed {
        logic      valid;
        logic      row;
        err_code_t err;
        logic      last;
    } slot_ctl_t;

    typedef struct packed {
        logic [63:0] rem;
        logic [31:0] quo;
        logic        neg;
        logic        sat;
    } div_lane_t;

    typedef struct packed {
        slot_ctl_t            ctl;
        logic [63:0]          dvsr;
        div_lane_t [LANES-1:0] lane;
    } div_word_t;

    // local row i picks rig axis axis[2i+1:2i]
    function automatic logic [5:0] face_axis(input logic [2:0] face);
        logic [5:0] r;
        r = {2'd2, 2'd1, 2'd0};
        unique case (face)
            FACE_FRONT: r = {2'd2, 2'd1, 2'd0};
            FACE_LEFT,
            FACE_RIGHT: r = {2'd0, 2'd1, 2'd2};
            FACE_LOWER,
            FACE_UPPER: r = {2'd1, 2'd2, 2'd0};
            default:    r = {2'd2, 2'd1, 2'd0};
        endcase
        return r;
    endfunction

    // sign flip of local row i at bit i
    function automatic logic [2:0] face_neg(input logic [2:0] face);
        logic [2:0] r;
        r = 3'b000;
        unique case (face)
            FACE_FRONT: r = 3'b000;
            FACE_LEFT:  r = 3'b100;
            FACE_RIGHT: r = 3'b001;
            FACE_LOWER: r = 3'b010;
            FACE_UPPER: r = 3'b100;
            default:    r = 3'b000;
        endcase
        return r;
    endfunction

endpackage

@@ hdl/cfpj_div_stage.sv @@
module cfpj_div_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  cfpj_pkg::div_word_t d_in,
    output cfpj_pkg::div_word_t d_out
);
    import cfpj_pkg::*;

    slot_ctl_t             ctl_reg;
    logic [63:0]           dvsr_reg;
    div_lane_t [LANES-1:0] lane_reg;
    div_lane_t [LANES-1:0] lane_next;

    // restoring division, a few quotient bits per stage
    always_comb
    begin
        logic [64:0] tmp;
        logic [64:0] diff;
        logic        ge;
        lane_next = d_in.lane;
        for (int l = 0; l < LANES; l++)
        begin
            for (int s = 0; s < DIV_STEPS; s++)
            begin
                tmp  = {lane_next[l].rem, lane_next[l].quo[31]};
                diff = tmp - {1'b0, d_in.dvsr};
                ge   = (tmp >= {1'b0, d_in.dvsr});
                lane_next[l].rem = ge ? diff[63:0] : tmp[63:0];
                lane_next[l].quo = {lane_next[l].quo[30:0], ge};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else
        begin
            ctl_reg <= d_in.ctl;
        end
    end

    always_ff @(posedge clk)
    begin
        dvsr_reg <= d_in.dvsr;
        lane_reg <= lane_next;
    end

    assign d_out.ctl  = ctl_reg;
    assign d_out.dvsr = dvsr_reg;
    assign d_out.lane = lane_reg;

endmodule

@@ hdl/cfpj_front.sv @@
module cfpj_front #(
    parameter int FRAC_BITS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                slot_valid,
    input  logic                slot_row,
    input  cfpj_pkg::in_item_t  item,
    input  logic [31:0]         focal_x,
    input  logic [31:0]         focal_y,
    output cfpj_pkg::div_word_t d_out
);
    import cfpj_pkg::*;

    // stage 1: face rotation and error check
    slot_ctl_t          s1_ctl_reg, s1_ctl_next;
    logic signed [32:0] s1_p_reg [3];
    logic [2:0]         s1_face_reg;
    logic [31:0]        s1_f_reg, s1_z_reg, s1_lmag_reg;
    logic               s1_lneg_reg;

    logic signed [32:0] ps [3];
    logic signed [32:0] loc [3];
    logic signed [32:0] locr;
    logic [5:0]         ax1;
    logic [2:0]         ng1;

    always_comb
    begin
        ps[0] = {item.point_x[31], item.point_x};
        ps[1] = {item.point_y[31], item.point_y};
        ps[2] = {item.point_z[31], item.point_z};
        ax1   = face_axis(item.face);
        ng1   = face_neg(item.face);
        for (int i = 0; i < 3; i++)
        begin
            loc[i] = ng1[i] ? -ps[ax1[2*i +: 2]] : ps[ax1[2*i +: 2]];
        end
        locr = slot_row ? loc[1] : loc[0];
        s1_ctl_next.row = slot_row;
        if (item.face > FACE_UPPER)
            s1_ctl_next.err = ERR_FACE;
        else if (loc[2][32] || loc[2] == '0)
            s1_ctl_next.err = ERR_DEPTH;
        else
            s1_ctl_next.err = ERR_NONE;
        s1_ctl_next.valid = slot_valid && !(slot_row && s1_ctl_next.err != ERR_NONE);
        s1_ctl_next.last  = slot_row || s1_ctl_next.err != ERR_NONE;
    end

    // stage 2: focal products and squared depth
    slot_ctl_t          s2_ctl_reg;
    logic signed [32:0] s2_p_reg [3];
    logic [2:0]         s2_face_reg;
    logic [63:0]        s2_fz_reg, s2_fl_reg, s2_den_reg;
    logic               s2_lneg_reg;

    // stage 3: pinhole row in rig frame, partial products
    slot_ctl_t   s3_ctl_reg;
    logic [63:0] s3_lo_reg [LANES];
    logic [63:0] s3_hi_reg [LANES];
    logic        s3_pn_reg [LANES];
    logic [63:0] s3_mmag_reg [3];
    logic        s3_mneg_reg [3];
    logic [63:0] s3_den_reg;

    logic [63:0] n_mag [3];
    logic        n_neg [3];
    logic [63:0] m_mag [3];
    logic        m_neg [3];
    logic [31:0] p_abs [3];
    logic [5:0]  ax3;
    logic [2:0]  ng3;
    logic [1:0]  pi_sel [LANES];
    logic [1:0]  mi_sel [LANES];

    always_comb
    begin
        logic signed [32:0] pa;
        ax3 = face_axis(s2_face_reg);
        ng3 = face_neg(s2_face_reg);
        n_mag[0] = s2_ctl_reg.row ? 64'd0 : s2_fz_reg;
        n_mag[1] = s2_ctl_reg.row ? s2_fz_reg : 64'd0;
        n_mag[2] = s2_fl_reg;
        n_neg[0] = 1'b0;
        n_neg[1] = 1'b0;
        n_neg[2] = !s2_lneg_reg;
        for (int i = 0; i < 3; i++)
        begin
            m_mag[i] = '0;
            m_neg[i] = 1'b0;
        end
        for (int i = 0; i < 3; i++)
        begin
            m_mag[ax3[2*i +: 2]] = n_mag[i];
            m_neg[ax3[2*i +: 2]] = n_neg[i] ^ ng3[i];
        end
        for (int i = 0; i < 3; i++)
        begin
            pa       = s2_p_reg[i][32] ? -s2_p_reg[i] : s2_p_reg[i];
            p_abs[i] = pa[31:0];
        end
        // lane 2k: p[b]*m[a], lane 2k+1: p[a]*m[b]
        pi_sel[0] = 2'd2; mi_sel[0] = 2'd1;
        pi_sel[1] = 2'd1; mi_sel[1] = 2'd2;
        pi_sel[2] = 2'd0; mi_sel[2] = 2'd2;
        pi_sel[3] = 2'd2; mi_sel[3] = 2'd0;
        pi_sel[4] = 2'd1; mi_sel[4] = 2'd0;
        pi_sel[5] = 2'd0; mi_sel[5] = 2'd1;
    end

    // stage 4: products and numerators
    slot_ctl_t          s4_ctl_reg;
    logic signed [97:0] s4_num_reg [LANES];
    logic [63:0]        s4_den_reg;

    logic signed [96:0] sprod [LANES];
    logic signed [97:0] num [LANES];

    always_comb
    begin
        logic [95:0]        prod;
        logic signed [64:0] tm;
        logic signed [97:0] tex;
        for (int j = 0; j < LANES; j++)
        begin
            prod     = {32'd0, s3_lo_reg[j]} + {s3_hi_reg[j], 32'd0};
            sprod[j] = s3_pn_reg[j] ? -$signed({1'b0, prod}) : $signed({1'b0, prod});
        end
        for (int k = 0; k < 3; k++)
        begin
            num[k] = {sprod[2*k][96], sprod[2*k]} - {sprod[2*k+1][96], sprod[2*k+1]};
            tm     = s3_mneg_reg[k] ? -$signed({1'b0, s3_mmag_reg[k]})
                                    : $signed({1'b0, s3_mmag_reg[k]});
            tex        = {{33{tm[64]}}, tm};
            num[3 + k] = -(tex <<< FRAC_BITS);
        end
    end

    // stage 5: magnitude, rounding offset, clip test
    div_word_t             f5_next;
    slot_ctl_t             f5_ctl_reg;
    logic [63:0]           f5_dvsr_reg;
    div_lane_t [LANES-1:0] f5_lane_reg;

    always_comb
    begin
        logic [97:0] mag;
        logic [97:0] nn;
        logic [97:0] lim;
        logic [63:0] dv;
        dv = {s4_den_reg[62:0], 1'b0};
        f5_next.ctl  = s4_ctl_reg;
        f5_next.dvsr = dv;
        for (int j = 0; j < LANES; j++)
        begin
            mag = s4_num_reg[j][97] ? 98'(-s4_num_reg[j]) : 98'(s4_num_reg[j]);
            nn  = {mag[96:0], 1'b0} + {34'd0, s4_den_reg};
            lim = {3'd0, dv, 31'd0} + (s4_num_reg[j][97] ? {34'd0, dv} : 98'd0);
            f5_next.lane[j].neg = s4_num_reg[j][97];
            f5_next.lane[j].sat = (nn >= lim);
            f5_next.lane[j].rem = nn[95:32];
            f5_next.lane[j].quo = nn[31:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_ctl_reg    <= '0;
            s2_ctl_reg    <= '0;
            s3_ctl_reg    <= '0;
            s4_ctl_reg    <= '0;
            f5_ctl_reg    <= '0;
        end
        else
        begin
            s1_ctl_reg <= s1_ctl_next;
            s2_ctl_reg <= s1_ctl_reg;
            s3_ctl_reg <= s2_ctl_reg;
            s4_ctl_reg <= s3_ctl_reg;
            f5_ctl_reg <= f5_next.ctl;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_p_reg    <= ps;
        s1_face_reg <= item.face;
        s1_f_reg    <= slot_row ? focal_y : focal_x;
        s1_z_reg    <= loc[2][31:0];
        s1_lmag_reg <= locr[32] ? 32'(-locr) : locr[31:0];
        s1_lneg_reg <= locr[32];

        s2_p_reg    <= s1_p_reg;
        s2_face_reg <= s1_face_reg;
        s2_fz_reg   <= s1_f_reg * s1_z_reg;
        s2_fl_reg   <= s1_f_reg * s1_lmag_reg;
        s2_den_reg  <= s1_z_reg * s1_z_reg;
        s2_lneg_reg <= s1_lneg_reg;

        for (int j = 0; j < LANES; j++)
        begin
            s3_lo_reg[j] <= p_abs[pi_sel[j]] * m_mag[mi_sel[j]][31:0];
            s3_hi_reg[j] <= p_abs[pi_sel[j]] * m_mag[mi_sel[j]][63:32];
            s3_pn_reg[j] <= s2_p_reg[pi_sel[j]][32] ^ m_neg[mi_sel[j]];
        end
        s3_mmag_reg <= m_mag;
        s3_mneg_reg <= m_neg;
        s3_den_reg  <= s2_den_reg;

        s4_num_reg <= num;
        s4_den_reg <= s3_den_reg;

        f5_dvsr_reg <= f5_next.dvsr;
        f5_lane_reg <= f5_next.lane;
    end

    assign d_out.ctl  = f5_ctl_reg;
    assign d_out.dvsr = f5_dvsr_reg;
    assign d_out.lane = f5_lane_reg;

endmodule

@@ hdl/cube_face_projection_jacobian_unit.sv @@
// takes a new point while the held one launches its v row; each point gives the
// u row then the v row on consecutive cycles, or one error result. the point rate
// is set by the single result port (two rows per point); the pipeline front, five
// arithmetic stages and eight divider stages take a row each cycle. async
// active-low reset clears control state and loads unit focals; results cannot be
// stalled.
`include "cube_face_projection_jacobian_unit_assert.svh"

module cube_face_projection_jacobian_unit #(
    parameter int FRAC_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    // command channel
    input  logic               start,
    output logic               busy,
    input  cfpj_pkg::in_item_t item,
    // result channel, one transfer per strobe
    output logic               result_valid,
    output cfpj_pkg::result_t  result,
    // configuration write channel
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic               cfg_index,
    input  logic [31:0]        cfg_data
);
    import cfpj_pkg::*;

    // focal length registers
    logic [31:0] focal_x_reg, focal_y_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            focal_x_reg <= 32'(1) << FRAC_BITS;
            focal_y_reg <= 32'(1) << FRAC_BITS;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_FOCAL_X: focal_x_reg <= cfg_data;
                CFG_FOCAL_Y: focal_y_reg <= cfg_data;
                default:     focal_x_reg <= focal_x_reg;
            endcase
        end
    end

    // issue: a held item launches the u row, then the v row
    in_item_t item_reg;
    logic     issue_reg, issue_next;
    logic     phase_reg, phase_next;
    logic     accept;

    assign busy   = issue_reg && !phase_reg;
    assign accept = start && !busy;

    always_comb
    begin
        issue_next = issue_reg;
        phase_next = phase_reg;
        if (accept)
        begin
            issue_next = 1'b1;
            phase_next = 1'b0;
        end
        else if (issue_reg && !phase_reg)
        begin
            phase_next = 1'b1;
        end
        else
        begin
            issue_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            issue_reg <= 1'b0;
            phase_reg <= 1'b0;
        end
        else
        begin
            issue_reg <= issue_next;
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            item_reg <= item;
    end

    // arithmetic front: rotation, products, numerators, clip test
    div_word_t div_chain [DIV_STAGES + 1];

    cfpj_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .slot_valid (issue_reg),
        .slot_row   (phase_reg),
        .item       (item_reg),
        .focal_x    (focal_x_reg),
        .focal_y    (focal_y_reg),
        .d_out      (div_chain[0])
    );

    // divider pipeline, all six entries of a row in parallel
    for (genvar g = 0; g < DIV_STAGES; g++)
    begin : g_div
        cfpj_div_stage u_stage (
            .clk   (clk),
            .rst_n (rst_n),
            .d_in  (div_chain[g]),
            .d_out (div_chain[g + 1])
        );
    end

    // final clip, sign and output register
    div_word_t   dw;
    logic [31:0] ent [LANES];
    logic        any_sat;
    result_t     result_next;
    logic        result_valid_reg;
    result_t     result_reg;

    assign dw = div_chain[DIV_STAGES];

    always_comb
    begin
        logic [32:0] mag;
        logic [32:0] sv;
        any_sat = 1'b0;
        for (int j = 0; j < LANES; j++)
        begin
            if (dw.lane[j].sat)
                mag = dw.lane[j].neg ? 33'h080000000 : 33'h07fffffff;
            else
                mag = {1'b0, dw.lane[j].quo};
            sv     = dw.lane[j].neg ? -mag : mag;
            ent[j] = (dw.ctl.err == ERR_NONE) ? sv[31:0] : 32'd0;
            any_sat = any_sat | dw.lane[j].sat;
        end
        result_next.row_index  = (dw.ctl.err == ERR_NONE) ? dw.ctl.row : 1'b0;
        result_next.j_rot_x    = ent[0];
        result_next.j_rot_y    = ent[1];
        result_next.j_rot_z    = ent[2];
        result_next.j_trans_x  = ent[3];
        result_next.j_trans_y  = ent[4];
        result_next.j_trans_z  = ent[5];
        result_next.saturated  = (dw.ctl.err == ERR_NONE) && any_sat;
        result_next.error_code = dw.ctl.err;
        result_next.last       = dw.ctl.last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= dw.ctl.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // an accepted command always raises busy in the next cycle
    `CFPJ_ASSERT_NXT(a_busy_after_accept, start && !busy, busy)
    // the u row is followed at once by the closing v row
    `CFPJ_ASSERT_NXT(a_v_follows_u, result_valid && !result.last,
                     result_valid && result.row_index && result.last)
    // an error result is a single row u
    `CFPJ_ASSERT_IMP(a_error_single, result_valid && result.error_code != ERR_NONE,
                     result.last && !result.row_index)

endmodule

@@ verif/tb_cube_face_projection_jacobian_unit.sv @@
`timescale 1ns / 100ps

module tb_cube_face_projection_jacobian_unit;
    import cfpj_pkg::*;

    localparam int FRAC = 16;
    localparam int STALL_LIMIT = 4000;   // idle cycles before the watchdog fires
    localparam int DRAIN_CYCLES = 40;    // extra wait after the last pending row has come back

    // jacobian expectation store with its own copy of the focal registers
    class jacobian_scoreboard;
        result_t      pending[$];
        logic [31:0]  fx;
        logic [31:0]  fy;
        int           errors;
        int           rows_seen;
        int           faults_seen;
        int           clipped_seen;
        int           ax[5][3];
        int           sg[5][3];

        function new();
            fx = 32'h0001_0000;
            fy = 32'h0001_0000;
            errors = 0;
            rows_seen = 0;
            faults_seen = 0;
            clipped_seen = 0;
            ax = '{'{0, 1, 2}, '{2, 1, 0}, '{2, 1, 0}, '{0, 2, 1}, '{0, 2, 1}};
            sg = '{'{1, 1, 1}, '{1, 1, -1}, '{-1, 1, 1}, '{1, -1, 1}, '{1, 1, -1}};
        endfunction

        task report(string what, logic [31:0] got, logic [31:0] want);
            errors++;
            $display("mismatch %0s: got %h want %h", what, got, want);
        endtask

        // exact quotient, rounded half away from zero, clipped to 32 bits
        function logic [31:0] round_clip(logic signed [127:0] num,
                                         logic [127:0] den, inout bit sat);
            logic [127:0] mag;
            logic [127:0] q;
            logic [127:0] rem;
            logic [127:0] lim;
            bit           neg;
            neg = num < 0;
            mag = neg ? -num : num;
            q = mag / den;
            rem = mag % den;
            if (rem >= den - rem)
                q = q + 1;
            lim = neg ? 128'h8000_0000 : 128'h7fff_ffff;
            if (q > lim)
            begin
                sat = 1;
                q = lim;
            end
            return neg ? -q[31:0] : q[31:0];
        endfunction

        function void note(in_item_t it);
            logic signed [127:0] p[3];
            logic signed [127:0] loc[3];
            logic signed [127:0] n[3];
            logic signed [127:0] m[3];
            logic signed [127:0] f;
            logic signed [127:0] rot;
            logic signed [127:0] tr;
            logic [127:0]        den;
            logic [31:0]         ent[6];
            result_t             res;
            bit                  sat;
            int                  fc;
            int                  a;
            int                  b;
            res = '0;
            res.last = 1'b1;
            p[0] = it.point_x;
            p[1] = it.point_y;
            p[2] = it.point_z;
            if (it.face > FACE_UPPER)
            begin
                res.error_code = ERR_FACE;
                pending.push_back(res);
                return;
            end
            fc = it.face;
            for (int i = 0; i < 3; i++)
                loc[i] = sg[fc][i] < 0 ? -p[ax[fc][i]] : p[ax[fc][i]];
            if (loc[2] <= 0)
            begin
                res.error_code = ERR_DEPTH;
                pending.push_back(res);
                return;
            end
            den = loc[2] * loc[2];
            for (int r = 0; r < 2; r++)
            begin
                f = {96'd0, (r == 1) ? fy : fx};
                sat = 0;
                n[0] = 0;
                n[1] = 0;
                n[r] = f * loc[2];
                n[2] = -(f * loc[r]);
                for (int i = 0; i < 3; i++)
                    m[ax[fc][i]] = sg[fc][i] < 0 ? -n[i] : n[i];
                for (int k = 0; k < 3; k++)
                begin
                    a = (k + 1) % 3;
                    b = (k + 2) % 3;
                    rot = p[b] * m[a] - p[a] * m[b];
                    tr = -(m[k] <<< FRAC);
                    ent[k] = round_clip(rot, den, sat);
                    ent[3 + k] = round_clip(tr, den, sat);
                end
                res.row_index = r[0];
                res.j_rot_x = ent[0];
                res.j_rot_y = ent[1];
                res.j_rot_z = ent[2];
                res.j_trans_x = ent[3];
                res.j_trans_y = ent[4];
                res.j_trans_z = ent[5];
                res.saturated = sat;
                res.error_code = ERR_NONE;
                res.last = (r == 1);
                pending.push_back(res);
            end
        endfunction

        task check(result_t got);
            result_t     want;
            logic [31:0] g[10];
            logic [31:0] w[10];
            string       names[10];
            if (pending.size() == 0)
            begin
                report("result with nothing pending", 32'd0, 32'd0);
                return;
            end
            want = pending.pop_front();
            rows_seen++;
            if (got.error_code != ERR_NONE)
                faults_seen++;
            if (got.saturated)
                clipped_seen++;
            names = '{"row_index", "j_rot_x", "j_rot_y", "j_rot_z", "j_trans_x",
                      "j_trans_y", "j_trans_z", "saturated", "error_code", "last"};
            g = '{got.row_index, got.j_rot_x, got.j_rot_y, got.j_rot_z, got.j_trans_x,
                  got.j_trans_y, got.j_trans_z, got.saturated, got.error_code, got.last};
            w = '{want.row_index, want.j_rot_x, want.j_rot_y, want.j_rot_z,
                  want.j_trans_x, want.j_trans_y, want.j_trans_z, want.saturated,
                  want.error_code, want.last};
            for (int i = 0; i < 10; i++)
                if (g[i] !== w[i])
                    report(names[i], g[i], w[i]);
        endtask
    endclass

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    in_item_t    item;
    logic        result_valid;
    result_t     result;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_index;
    logic [31:0] cfg_data;

    jacobian_scoreboard sb;
    int idle_cycles;
    int points_sent;

    cube_face_projection_jacobian_unit #(.FRAC_BITS(FRAC)) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .item         (item),
        .result_valid (result_valid),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // monitor: sample everything at the edge, before the driver's updates land
    always @(posedge clk)
    begin
        bit moved;
        moved = 1'b0;
        if (rst_n)
        begin
            if (start && !busy)
            begin
                sb.note(item);
                points_sent <= points_sent + 1;
                moved = 1'b1;
            end
            if (result_valid)
            begin
                sb.check(result);
                moved = 1'b1;
            end
            if (cfg_valid && cfg_ready)
            begin
                // mirror the register write into the predictor
                if (cfg_index == CFG_FOCAL_X)
                    sb.fx = cfg_data;
                else
                    sb.fy = cfg_data;
                moved = 1'b1;
            end
            idle_cycles <= moved ? 0 : idle_cycles + 1;
        end
    end

    // watchdog: nothing moved for too long
    always @(posedge clk)
    begin
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // one command transfer; start stays high so bursts run back to back
    task automatic push_point(in_item_t it);
        start <= 1'b1;
        item <= it;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic pause(int cycles);
        if (cycles > 0)
        begin
            start <= 1'b0;
            repeat (cycles) @(posedge clk);
        end
    endtask

    // wait for every pending row, then let the pipeline empty out
    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(cfg_reg_t idx, logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(4))
            0: return $urandom;
            1: return $signed($urandom) >>> $urandom_range(31);
            2: return $urandom_range(32'h0004_0000);
            3: return $urandom_range(1) ? 32'h7fff_ffff - $urandom_range(3)
                                        : 32'h8000_0000 + $urandom_range(3);
            default: return -$signed({16'd0, $urandom_range(16'hffff)} << $urandom_range(16));
        endcase
    endfunction

    // local depth of a point on a valid face, same signed axis pick as the predictor
    function automatic longint depth_of(in_item_t it);
        longint c[3];
        c[0] = it.point_x;
        c[1] = it.point_y;
        c[2] = it.point_z;
        case (it.face)
            FACE_FRONT: return c[2];
            FACE_LEFT:  return -c[0];
            FACE_RIGHT: return c[0];
            FACE_LOWER: return c[1];
            default:    return -c[1];
        endcase
    endfunction

    function automatic in_item_t rand_point();
        in_item_t it;
        int kind;
        kind = $urandom_range(99);
        it.point_x = rand_coord();
        it.point_y = rand_coord();
        it.point_z = rand_coord();
        if (kind < 6)
        begin
            it.face = 3'(FACE_UPPER) + 3'($urandom_range(1, 3));
        end
        else
        begin
            it.face = 3'($urandom_range(FACE_UPPER));
            // mostly points in front of the face, the rest with random depth
            if (kind >= 14)
                while (depth_of(it) <= 0)
                begin
                    it.point_x = rand_coord();
                    it.point_y = rand_coord();
                    it.point_z = rand_coord();
                end
        end
        return it;
    endfunction

    task automatic random_phase(int count);
        int left;
        int burst;
        left = count;
        while (left > 0)
        begin
            burst = $urandom_range(1, 16);
            for (int i = 0; i < burst && left > 0; i++)
            begin
                push_point(rand_point());
                left--;
            end
            if ($urandom_range(3) != 0)
                pause($urandom_range(1, 9));
        end
    endtask

    function automatic in_item_t mk(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                                    logic [2:0] fc);
        in_item_t it;
        it.point_x = x;
        it.point_y = y;
        it.point_z = z;
        it.face = fc;
        return it;
    endfunction

    initial
    begin
        logic [31:0] fx_set[5];
        logic [31:0] fy_set[5];
        sb = new();
        idle_cycles = 0;
        points_sent = 0;
        rst_n = 1'b0;
        start = 1'b0;
        item = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_FOCAL_X;
        cfg_data = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed points at reset focals: every face, extremes, both faults
        push_point(mk(32'h0001_0000, 32'h0002_0000, 32'h0001_0000, FACE_FRONT));
        push_point(mk(32'h7fff_ffff, 32'h8000_0000, 32'h0000_0001, FACE_FRONT));
        push_point(mk(32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, FACE_FRONT));
        push_point(mk(32'h8000_0000, 32'h0001_0000, 32'h0003_0000, FACE_LEFT));
        push_point(mk(32'h7fff_ffff, 32'hffff_0000, 32'h8000_0000, FACE_RIGHT));
        push_point(mk(32'h0001_8000, 32'h7fff_ffff, 32'h8000_0000, FACE_LOWER));
        push_point(mk(32'hfffe_0000, 32'h8000_0000, 32'h7fff_ffff, FACE_UPPER));
        push_point(mk(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, FACE_FRONT));
        push_point(mk(32'h0001_0000, 32'h0001_0000, 32'hffff_ffff, FACE_FRONT));
        push_point(mk(32'h0001_0000, 32'h0000_0000, 32'h0001_0000, FACE_LEFT));
        push_point(mk(32'h0000_0001, 32'h0000_0000, 32'h0001_0000, FACE_UPPER));
        push_point(mk(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 3'd5));
        push_point(mk(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 3'd6));
        push_point(mk(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 3'd7));
        push_point(mk(32'hffff_ffff, 32'hffff_ffff, 32'h0000_0001, FACE_FRONT));
        drain();

        // focal settings: zero, full scale, mixed, random
        fx_set = '{32'h0000_0000, 32'hffff_ffff, 32'h0000_0001, 32'h0200_0000, 32'h0};
        fy_set = '{32'hffff_ffff, 32'h0000_0000, 32'h8000_0000, 32'h0000_8000, 32'h0};
        fx_set[4] = $urandom;
        fy_set[4] = $urandom;
        random_phase(150);
        drain();
        for (int s = 0; s < 5; s++)
        begin
            write_reg(CFG_FOCAL_X, fx_set[s]);
            write_reg(CFG_FOCAL_Y, fy_set[s]);
            if (s == 1)
            begin
                push_point(mk(32'h7fff_ffff, 32'h8000_0000, 32'h0000_0001, FACE_FRONT));
                push_point(mk(32'h8000_0000, 32'h7fff_ffff, 32'h0000_0001, FACE_RIGHT));
            end
            random_phase(160);
            drain();
        end

        $display("covered %0d points, %0d result rows, %0d fault rows, %0d clipped rows",
                 points_sent, sb.rows_seen, sb.faults_seen, sb.clipped_seen);
        $display("focal settings swept: reset, zero, full scale and random values");
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+hdl
hdl/cfpj_pkg.sv
hdl/cfpj_div_stage.sv
hdl/cfpj_front.sv
hdl/cube_face_projection_jacobian_unit.sv
verif/tb_cube_face_projection_jacobian_unit.sv
